// ===== hdl/ray_box_slab_test_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RBS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the following cycle.
`define RBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/rbs_pkg.sv =====
package rbs_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned NumAxes = 3;

	typedef logic signed [WordW-1:0] word_t;

	typedef struct packed {
		word_t origin_x;
		word_t origin_y;
		word_t origin_z;
		word_t dir_x;
		word_t dir_y;
		word_t dir_z;
		word_t box_min_x;
		word_t box_min_y;
		word_t box_min_z;
		word_t box_max_x;
		word_t box_max_y;
		word_t box_max_z;
	} ray_box_t;

	typedef struct packed {
		logic  hit;
		word_t hit_distance;
	} result_t;
endpackage

// ===== hdl/rbs_if.sv =====
interface rbs_in_if;
	import rbs_pkg::*;
	logic     valid;
	logic     ready;
	ray_box_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rbs_out_if;
	import rbs_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/rbs_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// Side band data travels with each word. Advance is a global enable.
module rbs_div #(
	parameter int unsigned NW = 48,
	parameter int unsigned DW = 32,
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic          v_s [NW+1];
	logic [NW-1:0] n_s [NW+1];
	logic [DW:0]   r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic [SW-1:0] x_s [NW+1];

	always_comb begin
		v_s[0] = in_valid;
		n_s[0] = num;
		r_s[0] = '0;
		d_s[0] = den;
		x_s[0] = side_in;
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW+1:0] trial;
		logic [DW:0]   rem;
		logic [NW-1:0] nsh;
		always_comb begin
			trial = {r_s[i], n_s[i][NW-1]} - {2'b00, d_s[i]};
			rem = trial[DW+1] ? {r_s[i][DW-1:0], n_s[i][NW-1]} : trial[DW:0];
			nsh = {n_s[i][NW-2:0], ~trial[DW+1]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= nsh;
				r_s[i+1] <= rem;
				d_s[i+1] <= d_s[i];
				x_s[i+1] <= x_s[i];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quo = n_s[NW];
	assign side_out = x_s[NW];
endmodule

// ===== hdl/rbs_axis.sv =====
// One axis: prepares both slab divisions, then signs and saturates quotients.
module rbs_axis #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  rbs_pkg::word_t org,
	input  rbs_pkg::word_t dir,
	input  rbs_pkg::word_t lo,
	input  rbs_pkg::word_t hi,
	output logic          out_valid,
	output rbs_pkg::word_t t_enter,
	output rbs_pkg::word_t t_leave,
	output logic          zero_dir,
	output logic          zero_ok
);
	import rbs_pkg::*;
	localparam int unsigned NW = WordW + 1 + FRAC_BITS;
	localparam int unsigned SW = 4;

	// Stage 1: differences, magnitudes and signs.
	logic          v_s1;
	logic [NW-1:0] na_s1, nb_s1;
	logic [WordW-1:0] ud_s1;
	logic          sa_s1, sb_s1, z_s1, zok_s1;

	logic signed [WordW:0] da, db;
	logic [WordW:0] ma, mb;
	logic dneg;
	always_comb begin
		dneg = dir[WordW-1];
		// Entry uses the near bound, which is hi for a negative direction.
		da = dneg ? ({hi[WordW-1], hi} - {org[WordW-1], org})
			: ({lo[WordW-1], lo} - {org[WordW-1], org});
		db = dneg ? ({lo[WordW-1], lo} - {org[WordW-1], org})
			: ({hi[WordW-1], hi} - {org[WordW-1], org});
		ma = da[WordW] ? (~da + 1'b1) : da;
		mb = db[WordW] ? (~db + 1'b1) : db;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			na_s1 <= {ma, {FRAC_BITS{1'b0}}};
			nb_s1 <= {mb, {FRAC_BITS{1'b0}}};
			ud_s1 <= dneg ? (~dir + 1'b1) : dir;
			sa_s1 <= da[WordW] ^ dneg;
			sb_s1 <= db[WordW] ^ dneg;
			z_s1 <= (dir == '0);
			zok_s1 <= !((org > hi) || (org < lo));
		end
	end

	logic va, vb;
	logic [NW-1:0] qa, qb;
	logic [SW-1:0] xa, xb;
	logic [WordW-1:0] den_s1;
	assign den_s1 = z_s1 ? {{(WordW-1){1'b0}}, 1'b1} : ud_s1;

	rbs_div #(.NW(NW), .DW(WordW), .SW(SW)) u_da (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(na_s1), .den(den_s1),
		.side_in({sa_s1, sb_s1, z_s1, zok_s1}), .out_valid(va), .quo(qa),
		.side_out(xa));
	rbs_div #(.NW(NW), .DW(WordW), .SW(SW)) u_db (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(nb_s1), .den(den_s1),
		.side_in(4'b0), .out_valid(vb), .quo(qb), .side_out(xb));

	function automatic word_t sat(input logic [NW-1:0] q, input logic neg);
		word_t r;
		if (neg) begin
			if (q > NW'(33'h080000000)) r = {1'b1, {(WordW-1){1'b0}}};
			else r = word_t'(~q + 1'b1);
		end else begin
			if (q > NW'(32'h7fffffff)) r = {1'b0, {(WordW-1){1'b1}}};
			else r = word_t'(q);
		end
		return r;
	endfunction

	// Final stage: sign and saturation.
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= va & vb;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_enter <= sat(qa, xa[3]);
			t_leave <= sat(qb, xa[2]);
			zero_dir <= xa[1];
			zero_ok <= xa[0];
		end
	end
	assign out_valid = v_s2;
	logic unused_xb;
	assign unused_xb = ^xb;
endmodule

// ===== hdl/rbs_merge.sv =====
// Narrows the interval over the axes in two registered stages.
module rbs_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  rbs_pkg::word_t    t_enter [3],
	input  rbs_pkg::word_t    t_leave [3],
	input  logic [2:0]        zero_dir,
	input  logic [2:0]        zero_ok,
	output logic              out_valid,
	output rbs_pkg::result_t  res
);
	import rbs_pkg::*;
	localparam word_t QMin = {1'b1, {(WordW-1){1'b0}}};
	localparam word_t QMax = {1'b0, {(WordW-1){1'b1}}};

	word_t e_c [3];
	word_t l_c [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			e_c[a] = zero_dir[a] ? QMin : t_enter[a];
			l_c[a] = zero_dir[a] ? QMax : t_leave[a];
		end
	end

	logic v_s1, ok_s1;
	word_t e01_s1, l01_s1, e2_s1, l2_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	word_t e_f, l_f;
	logic ok_f;
	always_comb begin
		e_f = (e2_s1 > e01_s1) ? e2_s1 : e01_s1;
		l_f = (l2_s1 < l01_s1) ? l2_s1 : l01_s1;
		ok_f = ok_s1 && !(e_f > l_f) && !l_f[WordW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e01_s1 <= (e_c[1] > e_c[0]) ? e_c[1] : e_c[0];
			l01_s1 <= (l_c[1] < l_c[0]) ? l_c[1] : l_c[0];
			e2_s1 <= e_c[2];
			l2_s1 <= l_c[2];
			ok_s1 <= &(zero_ok | ~zero_dir);
			res.hit <= ok_f;
			res.hit_distance <= ok_f ? e_f : '0;
		end
	end
endmodule

// ===== hdl/ray_box_slab_test_top.sv =====
// Ray versus box slab test, one word accepted per cycle when not stalled.
// Pipeline: prep, one stage per quotient bit, saturate, and two merge stages,
// of which the second is the output register.
// The bit-per-stage dividers make up most of the pipeline depth.
// Throughput: one word per cycle; a stall on the output freezes the pipeline.
// Reset: arst_n clears all valid bits asynchronously; no data is reset.
module ray_box_slab_test_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	rbs_in_if.sink   in_ch,
	rbs_out_if.source out_ch
);
	import rbs_pkg::*;

	logic en;
	// The pipeline moves unless a result waits unread at the output.
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	word_t org [3], dir [3], lo [3], hi [3];
	assign org = '{in_ch.data.origin_x, in_ch.data.origin_y, in_ch.data.origin_z};
	assign dir = '{in_ch.data.dir_x, in_ch.data.dir_y, in_ch.data.dir_z};
	assign lo = '{in_ch.data.box_min_x, in_ch.data.box_min_y, in_ch.data.box_min_z};
	assign hi = '{in_ch.data.box_max_x, in_ch.data.box_max_y, in_ch.data.box_max_z};

	logic [2:0] av, zd, zk;
	word_t te [3], tl [3];
	for (genvar a = 0; a < 3; a++) begin : g_ax
		rbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
			.clk, .arst_n, .en, .in_valid(in_ch.valid), .org(org[a]), .dir(dir[a]),
			.lo(lo[a]), .hi(hi[a]), .out_valid(av[a]), .t_enter(te[a]),
			.t_leave(tl[a]), .zero_dir(zd[a]), .zero_ok(zk[a]));
	end

	rbs_merge u_merge (
		.clk, .arst_n, .en, .in_valid(&av), .t_enter(te), .t_leave(tl),
		.zero_dir(zd), .zero_ok(zk), .out_valid(out_ch.valid), .res(out_ch.data));
endmodule

// ===== hdl/rbs_checker.sv =====
`include "ray_box_slab_test_top_assert.svh"
module rbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic hit,
	input logic [31:0] hit_distance
);
	`RBS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(hit_distance))
	`RBS_ASSERT_IMP(a_miss_zero, out_valid && !hit, hit_distance == 32'd0)
	`RBS_ASSERT_IMP(a_ready, !out_valid, in_ready)
	`RBS_ASSERT_IMP(a_stall, out_valid && !out_ready, !in_ready)
endmodule

bind ray_box_slab_test_top rbs_checker u_rbs_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .hit(out_ch.data.hit),
	.hit_distance(out_ch.data.hit_distance));
